// ----- src/irsa_pkg.sv -----
// ----------------------------------------------------------------------------
// irsa_pkg: shared types and constants
// Sizes, operation and status codes, and the command that is broadcast to
// the row of storage cells of the insert/remove shift array.
// ----------------------------------------------------------------------------
`default_nettype none

package irsa_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 7;

  // read side: cells are OR-ed in groups, the group results are registered
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS   = OP_W + POS_W + DATA_W;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = DATA_W + STAT_W + LEN_W;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_FILL   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FILL,
    CELL_READ,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/insert_remove_shift_array.sv -----
// ----------------------------------------------------------------------------
// insert_remove_shift_array: ordered array with insert and remove
// Top level: operation decode, length register, row of cells, read-out and
// the two-deep result path to the output stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: fill, read, write, insert
//   or remove, with a position (index, or new length for fill) and a value.
//   m_axis returns exactly one result per operation: read data (zero unless a
//   successful read), a status (ok, index out of range, array full) and the
//   length after the operation.
//   Storage is a row of CAPACITY cells, one word each. Every cell decides on
//   its own from the broadcast command: it loads the value, takes its left
//   neighbor (insert) or its right neighbor (remove), so a whole shift is
//   done in the single cycle the operation is accepted.
//   A result is held first in the registered read groups and the stage
//   register, then in the output register that drives m_axis. Throughput is
//   one operation per cycle while m_axis is ready.
//   When m_axis stalls, one more operation is taken into the internal stage,
//   then s_axis_tready drops until the output register is drained.
//   Reset sets the length to zero and empties the result path; entry
//   contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module insert_remove_shift_array (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] op, [9:3] position, [41:10] value, zero padded above
  input  wire [irsa_pkg::IN_TDATA-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [31:0] read_data, [33:32] status, [40:34] length, zero padded above
  output logic [irsa_pkg::OUT_TDATA-1:0]     m_axis_tdata
);

  // input fields
  logic [irsa_pkg::OP_W-1:0]   op;
  logic [irsa_pkg::POS_W-1:0]  position;
  logic [irsa_pkg::DATA_W-1:0] value;

  assign op       = s_axis_tdata[irsa_pkg::OP_W-1:0];
  assign position = s_axis_tdata[irsa_pkg::OP_W +: irsa_pkg::POS_W];
  assign value    = s_axis_tdata[irsa_pkg::OP_W + irsa_pkg::POS_W +: irsa_pkg::DATA_W];

  // control
  logic                        accept;
  logic                        out_free;
  logic                        stage_move;

  logic [irsa_pkg::LEN_W-1:0]  count;
  logic [irsa_pkg::LEN_W-1:0]  count_next;
  irsa_pkg::status_t           status_dec;
  irsa_pkg::cell_op_t          kind_dec;
  irsa_pkg::cell_cmd_t         cmd;

  // result path: stage holds status/length while the read groups settle
  logic                        stage_valid;
  irsa_pkg::status_t           stage_status;
  logic [irsa_pkg::LEN_W-1:0]  stage_length;
  irsa_pkg::status_t           out_status;
  logic [irsa_pkg::LEN_W-1:0]  out_length;
  logic [irsa_pkg::DATA_W-1:0] out_read_data;
  logic [irsa_pkg::DATA_W-1:0] tree_data;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign stage_move    = stage_valid && out_free;
  assign s_axis_tready = !stage_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // operation decode against the current length
  always_comb begin
    status_dec = irsa_pkg::ST_OK;
    kind_dec   = irsa_pkg::CELL_HOLD;
    count_next = count;
    case (op)
      irsa_pkg::OP_FILL: begin
        if ({1'b0, position} > (irsa_pkg::POS_W+1)'(irsa_pkg::CAPACITY)) begin
          status_dec = irsa_pkg::ST_RANGE;
        end else begin
          kind_dec   = irsa_pkg::CELL_FILL;
          count_next = irsa_pkg::LEN_W'(position);
        end
      end
      irsa_pkg::OP_READ: begin
        if (position >= count) status_dec = irsa_pkg::ST_RANGE;
        else kind_dec = irsa_pkg::CELL_READ;
      end
      irsa_pkg::OP_WRITE: begin
        if (position >= count) status_dec = irsa_pkg::ST_RANGE;
        else kind_dec = irsa_pkg::CELL_WRITE;
      end
      irsa_pkg::OP_INSERT: begin
        if (position > count) begin
          status_dec = irsa_pkg::ST_RANGE;
        end else if ({1'b0, count} >= (irsa_pkg::LEN_W+1)'(irsa_pkg::CAPACITY)) begin
          status_dec = irsa_pkg::ST_FULL;
        end else begin
          kind_dec   = irsa_pkg::CELL_INSERT;
          count_next = count + irsa_pkg::LEN_W'(1);
        end
      end
      irsa_pkg::OP_REMOVE: begin
        if (position >= count) begin
          status_dec = irsa_pkg::ST_RANGE;
        end else begin
          kind_dec   = irsa_pkg::CELL_REMOVE;
          count_next = count - irsa_pkg::LEN_W'(1);
        end
      end
      default: begin
        status_dec = irsa_pkg::ST_RANGE;
      end
    endcase
  end

  // cells only act on an accepted transaction
  assign cmd.kind  = accept ? kind_dec : irsa_pkg::CELL_HOLD;
  assign cmd.pos   = position;
  assign cmd.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // row of cells
  logic [irsa_pkg::CAPACITY-1:0][irsa_pkg::DATA_W-1:0] cell_data;
  logic [irsa_pkg::CAPACITY-1:0][irsa_pkg::DATA_W-1:0] cell_sel;

  for (genvar i = 0; i < irsa_pkg::CAPACITY; i++) begin : g_cell
    logic [irsa_pkg::DATA_W-1:0] left_d;
    logic [irsa_pkg::DATA_W-1:0] right_d;

    // cell 0 never takes its left neighbor; the last cell keeps its own word
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == irsa_pkg::CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    irsa_cell u_cell (
      .clk        (clk),
      .index      (irsa_pkg::IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .sel_data   (cell_sel[i])
    );
  end

  irsa_read_tree u_read_tree (
    .clk       (clk),
    .load      (accept),
    .sel_data  (cell_sel),
    .read_data (tree_data)
  );

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_status <= status_dec;
      stage_length <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (stage_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_status    <= stage_status;
      out_length    <= stage_length;
      out_read_data <= tree_data;
    end
  end

  assign m_axis_tdata = irsa_pkg::OUT_TDATA'({out_length, out_status, out_read_data});

endmodule

`default_nettype wire

// ----- src/irsa_cell.sv -----
// ----------------------------------------------------------------------------
// irsa_cell: one entry of the shift array
// Holds one word; loads the broadcast value, or takes a neighbor's word on
// insert/remove, depending on its own index against the command position.
// ----------------------------------------------------------------------------
`default_nettype none

module irsa_cell (
  input  wire                          clk,
  input  wire [irsa_pkg::IDX_W-1:0]    index,
  input  irsa_pkg::cell_cmd_t          cmd,
  input  wire [irsa_pkg::DATA_W-1:0]   left_data,   // entry index-1
  input  wire [irsa_pkg::DATA_W-1:0]   right_data,  // entry index+1
  output logic [irsa_pkg::DATA_W-1:0]  data,
  output logic [irsa_pkg::DATA_W-1:0]  sel_data     // data when read here, else 0
);

  logic [irsa_pkg::POS_W:0]    idx_ext;
  logic [irsa_pkg::POS_W:0]    pos_ext;
  logic                        at_pos;
  logic                        above_pos;
  logic                        below_pos;
  logic [irsa_pkg::DATA_W-1:0] data_next;

  assign idx_ext   = (irsa_pkg::POS_W+1)'(index);
  assign pos_ext   = {1'b0, cmd.pos};
  assign at_pos    = (idx_ext == pos_ext);
  assign above_pos = (idx_ext > pos_ext);
  assign below_pos = (idx_ext < pos_ext);

  always_comb begin
    data_next = data;
    case (cmd.kind)
      irsa_pkg::CELL_FILL: begin
        if (below_pos) data_next = cmd.value;
      end
      irsa_pkg::CELL_WRITE: begin
        if (at_pos) data_next = cmd.value;
      end
      irsa_pkg::CELL_INSERT: begin
        if (above_pos) data_next = left_data;
        else if (at_pos) data_next = cmd.value;
      end
      irsa_pkg::CELL_REMOVE: begin
        if (at_pos || above_pos) data_next = right_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign sel_data = (cmd.kind == irsa_pkg::CELL_READ && at_pos) ? data : '0;

endmodule

`default_nettype wire

// ----- src/irsa_read_tree.sv -----
// ----------------------------------------------------------------------------
// irsa_read_tree: read-out of the selected cell
// ORs the masked cell words in groups into registers, then ORs the groups.
// ----------------------------------------------------------------------------
`default_nettype none

module irsa_read_tree (
  input  wire                                          clk,
  input  wire                                          load,
  input  wire [irsa_pkg::CAPACITY-1:0][irsa_pkg::DATA_W-1:0] sel_data,
  output logic [irsa_pkg::DATA_W-1:0]                  read_data
);

  logic [irsa_pkg::NGROUP-1:0][irsa_pkg::DATA_W-1:0] part_next;
  logic [irsa_pkg::NGROUP-1:0][irsa_pkg::DATA_W-1:0] part;

  always_comb begin
    for (int g = 0; g < irsa_pkg::NGROUP; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < irsa_pkg::GROUP; k++) begin
        if (g * irsa_pkg::GROUP + k < irsa_pkg::CAPACITY) begin
          part_next[g] = part_next[g] | sel_data[g * irsa_pkg::GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part <= part_next;
    end
  end

  always_comb begin
    read_data = '0;
    for (int g = 0; g < irsa_pkg::NGROUP; g++) begin
      read_data = read_data | part[g];
    end
  end

endmodule

`default_nettype wire
